// ===== design/image_block_binning_assert.svh =====
// assertion helpers, sampled on clk, quiet while arst_n is low
`ifndef IMAGE_BLOCK_BINNING_ASSERT_SVH
`define IMAGE_BLOCK_BINNING_ASSERT_SVH

// same-cycle implication
`define IBB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ibb_pkg.sv =====
package ibb_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_SCALE  = 8;
	localparam int PIXEL_BITS = 16;
	localparam int MAX_HEIGHT = 4096;

	localparam int SUM_W   = 22;
	localparam int ACC_W   = 19;
	localparam int CNT_W   = 12;
	localparam int DIM_W   = 13;
	localparam int SCALE_W = 4;
	localparam int SUB_W   = 3;
	localparam int IDX_W   = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_BIN_SCALE    = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_idx_t;

	// position of the current pixel within the frame and its block
	typedef struct packed {
		logic             in_block;
		logic             sub_col_zero;
		logic             col_last;
		logic             sub_row_zero;
		logic             sub_row_last;
		logic [CNT_W-1:0] addr;
		logic             row_end;
		logic             frame_end;
	} pos_t;

	function automatic logic [DIM_W-1:0] clamp_cfg(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== design/ibb_pix_if.sv =====
interface ibb_pix_if;
	logic                            valid;
	logic                            ready;
	logic [ibb_pkg::PIXEL_BITS-1:0]  pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

// ===== design/ibb_bin_if.sv =====
interface ibb_bin_if;
	logic                       valid;
	logic                       ready;
	logic [ibb_pkg::SUM_W-1:0]  bin_sum;
	logic                       row_end;
	logic                       frame_end;

	modport source (output valid, output bin_sum, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input bin_sum, input row_end, input frame_end,
		output ready);
endinterface

// ===== design/image_block_binning.sv =====
// Pixel binning: sums each scale x scale block of a raster image into one word.
// pix_in takes one pixel word per cycle in raster order (valid/ready).
// bin_out gives one sum word per whole block, with row_end on the last block
// of an output row and frame_end on the last block of the frame.
// Configuration: cfg_we with cfg_idx 0 = scale (1..8), 1 = width, 2 = height;
// any write restarts the frame. Write only while the block is idle.
// After the block's last pixel is accepted, its sum passes the line-store read
// stage and then the output register, which drives bin_out.
// Throughput: one pixel per cycle while bin_out is not stalled; each block
// column close does at most one read and one write-back of the 4096-entry line store.
// Reset: scale 2, 4096 x 4096, counters at the frame start. The line store is
// not cleared; every entry is written on a block's first row before it is read.
// When bin_out stalls, the output register holds its word; one more block sum
// can wait in the read stage, after which pix_in drops ready. Pixels that do
// not complete a block keep flowing while the output is stalled until then.
module image_block_binning (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ibb_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [ibb_pkg::DIM_W-1:0]   cfg_data,
	ibb_pix_if.sink                     pix_in,
	ibb_bin_if.source                   bin_out
);

	`include "image_block_binning_assert.svh"

	logic [ibb_pkg::SCALE_W-1:0] scale_q;
	logic [ibb_pkg::DIM_W-1:0]   width_q, height_q;
	logic [ibb_pkg::ACC_W-1:0]   row_acc_q, acc;
	ibb_pkg::pos_t               pos;
	logic                        accept, take;

	logic [ibb_pkg::SUM_W-1:0]   line_mem [ibb_pkg::MAX_WIDTH];
	logic [ibb_pkg::SUM_W-1:0]   rd_data_s1;
	logic                        rd_en, wr_en;

	logic                        v_s1_q;
	logic [ibb_pkg::ACC_W-1:0]   acc_s1;
	logic [ibb_pkg::CNT_W-1:0]   addr_s1;
	logic                        use_prev_s1, emit_s1, row_end_s1, frame_end_s1;
	logic                        adv_s1;
	logic [ibb_pkg::SUM_W-1:0]   line_sum;

	logic                        out_v_q;
	logic [ibb_pkg::SUM_W-1:0]   bin_sum_q;
	logic                        row_end_q, frame_end_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= ibb_pkg::SCALE_W'(2);
			width_q  <= ibb_pkg::DIM_W'(ibb_pkg::MAX_WIDTH);
			height_q <= ibb_pkg::DIM_W'(ibb_pkg::MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ibb_pkg::REG_BIN_SCALE: scale_q <= ibb_pkg::SCALE_W'(ibb_pkg::clamp_cfg(
					ibb_pkg::DIM_W'(cfg_data[ibb_pkg::SCALE_W-1:0]),
					ibb_pkg::DIM_W'(ibb_pkg::MAX_SCALE)));
				ibb_pkg::REG_IMAGE_WIDTH: width_q <= ibb_pkg::clamp_cfg(cfg_data,
					ibb_pkg::DIM_W'(ibb_pkg::MAX_WIDTH));
				ibb_pkg::REG_IMAGE_HEIGHT: height_q <= ibb_pkg::clamp_cfg(cfg_data,
					ibb_pkg::DIM_W'(ibb_pkg::MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	ibb_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.step    (accept),
		.scale   (scale_q),
		.width   (width_q),
		.height  (height_q),
		.pos     (pos)
	);

	assign take   = bin_out.valid && bin_out.ready;
	assign adv_s1 = v_s1_q && (!emit_s1 || !out_v_q || bin_out.ready);
	assign pix_in.ready = !v_s1_q || adv_s1;
	assign accept = pix_in.valid && pix_in.ready;

	assign acc = (pos.sub_col_zero ? '0 : row_acc_q) + ibb_pkg::ACC_W'(pix_in.pixel);

	// horizontal accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_acc_q <= '0;
		end else if (cfg_we) begin
			row_acc_q <= '0;
		end else if (accept && pos.in_block) begin
			row_acc_q <= pos.col_last ? '0 : acc;
		end
	end

	// line store: read on the column close, write back as the word leaves the read stage
	assign rd_en    = accept && pos.in_block && pos.col_last && !pos.sub_row_zero;
	assign wr_en    = adv_s1 && !emit_s1;
	assign line_sum = (use_prev_s1 ? rd_data_s1 : '0) + ibb_pkg::SUM_W'(acc_s1);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= line_mem[pos.addr];
		end
		if (wr_en) begin
			line_mem[addr_s1] <= line_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept && pos.in_block && pos.col_last) begin
			v_s1_q <= 1'b1;
		end else if (adv_s1) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos.in_block && pos.col_last) begin
			acc_s1       <= acc;
			addr_s1      <= pos.addr;
			use_prev_s1  <= !pos.sub_row_zero;
			emit_s1      <= pos.sub_row_last;
			row_end_s1   <= pos.row_end;
			frame_end_s1 <= pos.frame_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			bin_sum_q   <= line_sum;
			row_end_q   <= row_end_s1;
			frame_end_q <= frame_end_s1;
		end
	end

	assign bin_out.valid     = out_v_q;
	assign bin_out.bin_sum   = bin_sum_q;
	assign bin_out.row_end   = row_end_q;
	assign bin_out.frame_end = frame_end_q;

	`IBB_ASSERT_NOW(a_no_rw_clash, rd_en && wr_en, pos.addr != addr_s1,
		"line store read and write hit the same entry")
	`IBB_ASSERT_NEXT(a_hold_s1, v_s1_q && emit_s1 && out_v_q && !bin_out.ready,
		v_s1_q && emit_s1, "block sum left the read stage while output was stalled")
	`IBB_ASSERT_NOW(a_frame_row, out_v_q && frame_end_q, row_end_q,
		"frame end without row end")
	`IBB_ASSERT_NOW(a_no_accept_full, v_s1_q && !adv_s1, !pix_in.ready,
		"pixel taken while read stage is blocked")

endmodule

// ===== design/ibb_raster.sv =====
module ibb_raster (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic                          step,
	input  logic [ibb_pkg::SCALE_W-1:0]   scale,
	input  logic [ibb_pkg::DIM_W-1:0]     width,
	input  logic [ibb_pkg::DIM_W-1:0]     height,
	output ibb_pkg::pos_t                 pos
);

	logic [ibb_pkg::CNT_W-1:0] col_q, row_q, blk_q;
	logic [ibb_pkg::SUB_W-1:0] sub_col_q, sub_row_q;
	logic [ibb_pkg::SUB_W-1:0] s_m1;
	logic [ibb_pkg::DIM_W-1:0] col_w, row_w, scale_w;
	logic                      fit_col, fit_row, last_col, last_row;

	always_comb begin
		s_m1    = ibb_pkg::SUB_W'(scale - ibb_pkg::SCALE_W'(1));
		col_w   = {1'b0, col_q};
		row_w   = {1'b0, row_q};
		scale_w = ibb_pkg::DIM_W'(scale);
		// block start plus scale must not pass the image edge
		fit_col  = (col_w - ibb_pkg::DIM_W'(sub_col_q) + scale_w) <= width;
		fit_row  = (row_w - ibb_pkg::DIM_W'(sub_row_q) + scale_w) <= height;
		last_col = col_w >= (width - ibb_pkg::DIM_W'(1));
		last_row = row_w >= (height - ibb_pkg::DIM_W'(1));

		pos.in_block     = fit_col && fit_row;
		pos.sub_col_zero = sub_col_q == '0;
		pos.col_last     = sub_col_q >= s_m1;
		pos.sub_row_zero = sub_row_q == '0;
		pos.sub_row_last = sub_row_q >= s_m1;
		pos.addr         = blk_q;
		pos.row_end      = (col_w + ibb_pkg::DIM_W'(1) + scale_w) > width;
		pos.frame_end    = pos.row_end && ((row_w + ibb_pkg::DIM_W'(1) + scale_w) > height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			blk_q     <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
		end else if (restart) begin
			col_q     <= '0;
			row_q     <= '0;
			blk_q     <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
		end else if (step) begin
			if (last_col) begin
				col_q     <= '0;
				blk_q     <= '0;
				sub_col_q <= '0;
				if (last_row) begin
					row_q     <= '0;
					sub_row_q <= '0;
				end else begin
					row_q     <= row_q + ibb_pkg::CNT_W'(1);
					sub_row_q <= pos.sub_row_last ? '0 : sub_row_q + ibb_pkg::SUB_W'(1);
				end
			end else begin
				col_q <= col_q + ibb_pkg::CNT_W'(1);
				if (pos.col_last) begin
					sub_col_q <= '0;
					blk_q     <= blk_q + ibb_pkg::CNT_W'(1);
				end else begin
					sub_col_q <= sub_col_q + ibb_pkg::SUB_W'(1);
				end
			end
		end
	end

endmodule
